[rtl/core/art_pkg.sv]
// Package: shared types and codes of the address region table.
`timescale 1ns / 1ps
package art_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BAD     = 3'd4;
  localparam logic [2:0] ST_WINDOW  = 3'd5;

  localparam int FL_READ  = 0;
  localparam int FL_WRITE = 1;
  localparam int FL_STACK = 3;

  typedef struct packed {
    logic [63:0] rstart;
    logic [63:0] rend;
    logic [3:0]  rflags;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

[rtl/core/address_region_table.sv]
// Top level: sorted address region table with lookup cache and access check.
`timescale 1ns / 1ps
// Regions live in one RAM, one entry each, read one entry per cycle. An item
// is taken when start is high and busy is low; its result appears on status
// and hit_* for a single cycle marked by done and cannot be held off. Clear,
// rejected window checks and inserts with a bad range or a full table are
// answered from the idle state, with done in the cycle after they are taken.
// A lookup tries the cached entry first and otherwise scans the table in
// order. Insert scans up to the insert position and then moves every later
// entry up one per cycle. A span check repeats the lookup for each region
// the span crosses.
module address_region_table
  import art_pkg::*;
#(
  parameter int MAX_REGIONS = 64,
  parameter int PAGE_SIZE   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [63:0] addr,
  input  logic [63:0] region_end,
  input  logic [3:0]  region_flags,
  input  logic [31:0] span_length,
  input  logic        write_access,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [63:0] hit_start,
  output logic [63:0] hit_end,
  output logic [3:0]  hit_flags
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FCACHE = 3'd1;
  localparam logic [2:0] S_FSCAN  = 3'd2;
  localparam logic [2:0] S_FDONE  = 3'd3;
  localparam logic [2:0] S_ISCAN  = 3'd4;
  localparam logic [2:0] S_IPREP  = 3'd5;
  localparam logic [2:0] S_ISHIFT = 3'd6;
  localparam logic [2:0] S_IWRITE = 3'd7;

  logic [2:0]    state;
  logic [1:0]    op_q;
  logic [63:0]   cur;
  logic [63:0]   lim;
  logic [3:0]    flags_q;
  logic          wr_q;
  logic [CW-1:0] idx;
  logic          dv;
  logic [IW-1:0] d_idx;
  logic [63:0]   prev_end;
  logic          have_prev;
  logic [IW-1:0] pos;
  logic [IW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic [IW-1:0] cache_idx;
  logic          cache_valid;
  logic [63:0]   user_base;
  logic [63:0]   user_top;
  logic [63:0]   hs;
  logic [63:0]   he;
  logic [3:0]    hf;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic [IW-1:0] raddr;
  entry_t        rd;
  logic [EntryW-1:0] rdata_raw;

  logic          accept;
  logic [63:0]   span_end;
  logic          window_ok;
  logic          cache_usable;
  logic          hit;
  logic          scan_more;
  logic          le_cur;
  logic [63:0]   pend_eff;
  logic          have_eff;
  logic          perm_ok;
  logic          guard_hit;

  art_ram #(
    .WIDTH(EntryW),
    .DEPTH(MAX_REGIONS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rd = entry_t'(rdata_raw);

  assign busy         = (state != S_IDLE);
  assign accept       = start && !busy;
  assign span_end     = addr + {32'd0, span_length};
  assign window_ok    = (user_base <= addr) && (addr < span_end) && (span_end <= user_top);
  assign cache_usable = cache_valid && ({1'b0, cache_idx} < count);
  assign hit          = (rd.rstart <= cur) && (cur < rd.rend);
  assign scan_more    = (idx < count);
  assign le_cur       = rd.rstart <= cur;
  assign pend_eff     = dv ? rd.rend : prev_end;
  assign have_eff     = dv || have_prev;
  assign perm_ok      = wr_q ? hf[FL_WRITE] : hf[FL_READ];
  assign guard_hit    = wr_q && hf[FL_STACK] && ((cur - hs) < 64'(PAGE_SIZE));

  always_comb begin
    raddr = cache_idx;
    we    = 1'b0;
    waddr = wr_ptr;
    wdata = rd;
    case (state)
      S_FSCAN, S_ISCAN: begin
        raddr = idx[IW-1:0];
      end
      S_IPREP: begin
        raddr = IW'(count - CW'(1));
      end
      S_ISHIFT: begin
        raddr = wr_ptr - IW'(2);
        we    = 1'b1;
      end
      S_IWRITE: begin
        we    = 1'b1;
        waddr = pos;
        wdata = '{rstart: cur, rend: lim, rflags: flags_q};
      end
      default: begin
        raddr = cache_idx;
      end
    endcase
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      user_base <= 64'h20_0000;
      user_top  <= 64'h8000_0000;
    end else if (cfg_write) begin
      if (cfg_index) begin
        user_top <= cfg_data;
      end else begin
        user_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      cache_idx   <= '0;
      cache_valid <= 1'b0;
      done        <= 1'b0;
      dv          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= op;
            cur       <= addr;
            flags_q   <= region_flags;
            wr_q      <= write_access;
            hit_start <= '0;
            hit_end   <= '0;
            hit_flags <= '0;
            idx       <= '0;
            dv        <= 1'b0;
            have_prev <= 1'b0;
            lim       <= (op == OP_INSERT) ? region_end : span_end;
            case (op)
              OP_INSERT: begin
                if (addr >= region_end) begin
                  done   <= 1'b1;
                  status <= ST_BAD;
                end else if (count >= CW'(MAX_REGIONS)) begin
                  done   <= 1'b1;
                  status <= ST_FULL;
                end else begin
                  state <= S_ISCAN;
                end
              end
              OP_CLEAR: begin
                count       <= '0;
                cache_idx   <= '0;
                cache_valid <= 1'b0;
                done        <= 1'b1;
                status      <= ST_OK;
              end
              default: begin
                if (op == OP_CHECK && !window_ok) begin
                  done   <= 1'b1;
                  status <= ST_WINDOW;
                end else begin
                  state <= cache_usable ? S_FCACHE : S_FSCAN;
                end
              end
            endcase
          end
        end

        S_FCACHE: begin
          if (hit) begin
            hs    <= rd.rstart;
            he    <= rd.rend;
            hf    <= rd.rflags;
            state <= S_FDONE;
          end else begin
            idx   <= '0;
            dv    <= 1'b0;
            state <= S_FSCAN;
          end
        end

        S_FSCAN: begin
          if (dv && hit) begin
            hs          <= rd.rstart;
            he          <= rd.rend;
            hf          <= rd.rflags;
            cache_idx   <= d_idx;
            cache_valid <= 1'b1;
            dv          <= 1'b0;
            state       <= S_FDONE;
          end else if (scan_more) begin
            d_idx <= idx[IW-1:0];
            dv    <= 1'b1;
            idx   <= idx + CW'(1);
          end else begin
            dv     <= 1'b0;
            done   <= 1'b1;
            status <= ST_MISS;
            state  <= S_IDLE;
          end
        end

        S_FDONE: begin
          if (op_q == OP_LOOKUP) begin
            done      <= 1'b1;
            status    <= ST_OK;
            hit_start <= hs;
            hit_end   <= he;
            hit_flags <= hf;
            state     <= S_IDLE;
          end else if (!perm_ok || guard_hit) begin
            done   <= 1'b1;
            status <= ST_MISS;
            state  <= S_IDLE;
          end else if (he < lim) begin
            // Advance the walk to the end of this region.
            cur   <= he;
            idx   <= '0;
            dv    <= 1'b0;
            state <= cache_usable ? S_FCACHE : S_FSCAN;
          end else begin
            done   <= 1'b1;
            status <= ST_OK;
            state  <= S_IDLE;
          end
        end

        S_ISCAN: begin
          if (dv && !le_cur) begin
            pos <= d_idx;
            dv  <= 1'b0;
            if ((rd.rstart < lim) || (have_prev && (prev_end > cur))) begin
              done   <= 1'b1;
              status <= ST_OVERLAP;
              state  <= S_IDLE;
            end else begin
              state <= S_IPREP;
            end
          end else begin
            if (dv) begin
              prev_end  <= rd.rend;
              have_prev <= 1'b1;
            end
            if (scan_more) begin
              d_idx <= idx[IW-1:0];
              dv    <= 1'b1;
              idx   <= idx + CW'(1);
            end else begin
              pos <= count[IW-1:0];
              dv  <= 1'b0;
              if (have_eff && (pend_eff > cur)) begin
                done   <= 1'b1;
                status <= ST_OVERLAP;
                state  <= S_IDLE;
              end else begin
                state <= S_IPREP;
              end
            end
          end
        end

        S_IPREP: begin
          wr_ptr <= count[IW-1:0];
          state  <= ({1'b0, pos} == count) ? S_IWRITE : S_ISHIFT;
        end

        S_ISHIFT: begin
          // Move entry wr_ptr-1 up one slot; stop once the gap is at pos.
          if ((wr_ptr - IW'(1)) == pos) begin
            state <= S_IWRITE;
          end else begin
            wr_ptr <= wr_ptr - IW'(1);
          end
        end

        S_IWRITE: begin
          if (cache_valid && (cache_idx >= pos)) begin
            cache_idx <= cache_idx + IW'(1);
          end
          count  <= count + CW'(1);
          done   <= 1'b1;
          status <= ST_OK;
          state  <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/art_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
